>>> rtl/csvt_pkg.sv
// Shared types, constants and codes of the CSV field tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

	// Field widths and limits
	localparam int BYTE_W      = 8;
	localparam int COL_W       = 7;
	localparam int MAX_COLUMNS = 64;

	// Result queue sizing
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// Special characters
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

	// Line modes
	localparam logic [1:0] LINE_CRLF = 2'd0;
	localparam logic [1:0] LINE_LF   = 2'd1;
	localparam logic [1:0] LINE_ANY  = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_CONTENT   = 2'd0;
	localparam logic [1:0] KIND_FIELD_END = 2'd1;
	localparam logic [1:0] KIND_ROW_END   = 2'd2;
	localparam logic [1:0] KIND_ERROR     = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_SHORT    = 2'd1;
	localparam logic [1:0] ERR_TOO_MANY = 2'd2;
	localparam logic [1:0] ERR_MID_ROW  = 2'd3;

	// Quote tracking
	typedef enum logic [2:0] {
		QP_OUT   = 3'b001,
		QP_IN    = 3'b010,
		QP_AFTER = 3'b100
	} quote_phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [1:0]        kind;
		logic [1:0]        error_code;
		logic [COL_W-1:0]  column_number;
		logic              last_of_item;
	} result_t;

	// Up to two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic result_t make_result(
		input logic [BYTE_W-1:0] out_byte,
		input logic [1:0]        kind,
		input logic [1:0]        error_code,
		input logic [COL_W-1:0]  column_number
	);
		result_t r;
		r.out_byte      = out_byte;
		r.kind          = kind;
		r.error_code    = error_code;
		r.column_number = column_number;
		r.last_of_item  = 1'b0;
		return r;
	endfunction

endpackage

>>> rtl/csvt_if.sv
// Channel interfaces of the CSV field tokenizer: input bytes, results, configuration.
`timescale 1ns / 1ps

interface csvt_in_if;
	logic                      valid;
	logic                      ready;
	logic [csvt_pkg::BYTE_W-1:0] in_byte;
	logic                      end_of_data;

	modport source(output valid, output in_byte, output end_of_data, input ready);
	modport sink(input valid, input in_byte, input end_of_data, output ready);
endinterface

interface csvt_out_if;
	logic                        valid;
	logic                        ready;
	logic [csvt_pkg::BYTE_W-1:0] out_byte;
	logic [1:0]                  kind;
	logic [1:0]                  error_code;
	logic [csvt_pkg::COL_W-1:0]  column_number;
	logic                        last_of_item;

	modport source(output valid, output out_byte, output kind, output error_code,
		output column_number, output last_of_item, input ready);
	modport sink(input valid, input out_byte, input kind, input error_code,
		input column_number, input last_of_item, output ready);
endinterface

interface csvt_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] line_mode;

	modport source(output valid, output line_mode, input ready);
	modport sink(input valid, input line_mode, output ready);
endinterface

>>> rtl/csvt_core.sv
// Input register, parse state and per-byte result decision of the CSV field tokenizer.
`timescale 1ns / 1ps

module csvt_core (
	input  logic                  clk,
	input  logic                  arst_n,
	csvt_in_if.sink               bytes,
	input  logic [1:0]            line_mode,
	input  logic                  room,
	output csvt_pkg::push_t       push
);

	// Input stage
	logic                          valid_s1;
	logic [csvt_pkg::BYTE_W-1:0]   byte_s1;
	logic                          eod_s1;
	logic                          fire;

	// Parse state
	csvt_pkg::quote_phase_t        quote_phase_q;
	logic                          cr_pending_q;
	logic                          at_row_start_q;
	logic                          learning_row_q;
	logic [csvt_pkg::COL_W-1:0]    column_total_q;
	logic [csvt_pkg::COL_W-1:0]    column_index_q;

	// Next state and results
	csvt_pkg::quote_phase_t        qp;
	logic                          crp;
	logic                          ars;
	logic                          lrn;
	logic [csvt_pkg::COL_W-1:0]    ctot;
	logic [csvt_pkg::COL_W-1:0]    cidx;
	logic [csvt_pkg::COL_W:0]      cnt;
	logic [1:0]                    err;
	logic                          done;
	logic                          do_end;
	csvt_pkg::push_t               res;

	function automatic csvt_pkg::push_t add_result(
		input csvt_pkg::push_t p,
		input csvt_pkg::result_t r
	);
		csvt_pkg::push_t q;
		q = p;
		if (p.count == 2'd0) begin
			q.first = r;
		end else begin
			q.second = r;
		end
		q.count = p.count + 2'd1;
		return q;
	endfunction

	assign fire        = valid_s1 && room;
	assign bytes.ready = !valid_s1 || fire;

	// Hold the accepted byte until the queue can take its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
			eod_s1  <= bytes.end_of_data;
		end
	end

	// Decide the results of one byte and the next parse state
	always_comb begin
		qp     = quote_phase_q;
		crp    = cr_pending_q;
		ars    = at_row_start_q;
		lrn    = learning_row_q;
		ctot   = column_total_q;
		cidx   = column_index_q;
		cnt    = '0;
		err    = csvt_pkg::ERR_NONE;
		done   = 1'b0;
		do_end = 1'b0;
		res    = '0;

		// Quoted text
		unique case (quote_phase_q)
			csvt_pkg::QP_AFTER: begin
				if (byte_s1 == csvt_pkg::CH_QUOTE) begin
					res  = add_result(res, csvt_pkg::make_result(csvt_pkg::CH_QUOTE,
						csvt_pkg::KIND_CONTENT, csvt_pkg::ERR_NONE, cidx));
					ars  = 1'b0;
					qp   = csvt_pkg::QP_IN;
					done = 1'b1;
				end else begin
					qp = csvt_pkg::QP_OUT;
				end
			end
			csvt_pkg::QP_IN: begin
				done = 1'b1;
				if (byte_s1 == csvt_pkg::CH_QUOTE) begin
					qp = csvt_pkg::QP_AFTER;
				end else begin
					res = add_result(res, csvt_pkg::make_result(byte_s1,
						csvt_pkg::KIND_CONTENT, csvt_pkg::ERR_NONE, cidx));
					ars = 1'b0;
				end
			end
			csvt_pkg::QP_OUT: begin
			end
			default: begin
				qp = csvt_pkg::QP_OUT;
			end
		endcase

		// Resolve a pending CR: row end on LF, else a content CR
		if (!done && crp) begin
			crp = 1'b0;
			if (byte_s1 == csvt_pkg::CH_LF) begin
				do_end = 1'b1;
				done   = 1'b1;
			end else begin
				res = add_result(res, csvt_pkg::make_result(csvt_pkg::CH_CR,
					csvt_pkg::KIND_CONTENT, csvt_pkg::ERR_NONE, cidx));
				ars = 1'b0;
			end
		end

		// Unquoted text
		if (!done) begin
			if (byte_s1 == csvt_pkg::CH_QUOTE) begin
				qp  = csvt_pkg::QP_IN;
				ars = 1'b0;
			end else if (byte_s1 == csvt_pkg::CH_COMMA) begin
				res = add_result(res, csvt_pkg::make_result('0,
					csvt_pkg::KIND_FIELD_END, csvt_pkg::ERR_NONE, cidx));
				if (cidx < csvt_pkg::COL_W'(csvt_pkg::MAX_COLUMNS)) begin
					cidx = cidx + 1'b1;
				end
				ars = 1'b0;
			end else if (byte_s1 == csvt_pkg::CH_CR && line_mode == csvt_pkg::LINE_CRLF) begin
				crp = 1'b1;
			end else if ((byte_s1 == csvt_pkg::CH_CR && line_mode[1])
					|| byte_s1 == csvt_pkg::CH_LF) begin
				do_end = 1'b1;
			end else begin
				res = add_result(res, csvt_pkg::make_result(byte_s1,
					csvt_pkg::KIND_CONTENT, csvt_pkg::ERR_NONE, cidx));
				ars = 1'b0;
			end
		end

		// Close the row and check its field count; blank lines give nothing
		if (do_end && !ars) begin
			cnt = {1'b0, cidx} + 1'b1;
			if (lrn) begin
				if (cnt > (csvt_pkg::COL_W + 1)'(csvt_pkg::MAX_COLUMNS)) begin
					err  = csvt_pkg::ERR_TOO_MANY;
					ctot = csvt_pkg::COL_W'(csvt_pkg::MAX_COLUMNS);
				end else begin
					ctot = cnt[csvt_pkg::COL_W-1:0];
				end
				lrn = 1'b0;
			end else if (cnt < {1'b0, ctot}) begin
				err = csvt_pkg::ERR_SHORT;
			end else if (cnt > {1'b0, ctot}) begin
				err = csvt_pkg::ERR_TOO_MANY;
			end
			res = add_result(res, csvt_pkg::make_result('0,
				(err != csvt_pkg::ERR_NONE) ? csvt_pkg::KIND_ERROR : csvt_pkg::KIND_ROW_END,
				err, cidx));
			cidx = '0;
			ars  = 1'b1;
		end

		// End of text: flag an unfinished row, then start over
		if (eod_s1) begin
			if (!(ars && qp == csvt_pkg::QP_OUT && !crp)) begin
				res = '0;
				res = add_result(res, csvt_pkg::make_result('0,
					csvt_pkg::KIND_ERROR, csvt_pkg::ERR_MID_ROW, cidx));
			end
			qp   = csvt_pkg::QP_OUT;
			crp  = 1'b0;
			ars  = 1'b1;
			lrn  = 1'b1;
			ctot = '0;
			cidx = '0;
		end

		// Mark the final result of this byte
		if (res.count == 2'd1) begin
			res.first.last_of_item = 1'b1;
		end else if (res.count == 2'd2) begin
			res.second.last_of_item = 1'b1;
		end

		push = res;
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	// Advance the parse state once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_phase_q  <= csvt_pkg::QP_OUT;
			cr_pending_q   <= 1'b0;
			at_row_start_q <= 1'b1;
			learning_row_q <= 1'b1;
			column_total_q <= '0;
			column_index_q <= '0;
		end else if (fire) begin
			quote_phase_q  <= qp;
			cr_pending_q   <= crp;
			at_row_start_q <= ars;
			learning_row_q <= lrn;
			column_total_q <= ctot;
			column_index_q <= cidx;
		end
	end

`ifndef NO_ASSERTIONS
	a_cr_outside_quotes: assert property (@(posedge clk) disable iff (!arst_n)
		cr_pending_q |-> quote_phase_q == csvt_pkg::QP_OUT)
		else $error("CR pending while inside quotes");

	a_eod_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eod_s1 |=> at_row_start_q && learning_row_q && !cr_pending_q
			&& column_index_q == '0 && column_total_q == '0)
		else $error("state not restarted after end of data");

	a_column_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		column_index_q <= csvt_pkg::COL_W'(csvt_pkg::MAX_COLUMNS))
		else $error("column index beyond limit");

	a_total_learned: assert property (@(posedge clk) disable iff (!arst_n)
		!learning_row_q |-> column_total_q != '0)
		else $error("column total empty after first row");
`endif

endmodule

>>> rtl/csvt_result_fifo.sv
// Result queue of the CSV field tokenizer: takes up to two results, gives one per transfer.
`timescale 1ns / 1ps

module csvt_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  csvt_pkg::push_t   push,
	output logic              room,
	csvt_out_if.source        results
);

	csvt_pkg::result_t               mem_q [csvt_pkg::FIFO_DEPTH];
	logic [csvt_pkg::FIFO_AW-1:0]    wr_q;
	logic [csvt_pkg::FIFO_AW-1:0]    rd_q;
	logic [csvt_pkg::FIFO_AW:0]      count_q;
	logic [csvt_pkg::FIFO_AW-1:0]    wr_next;
	logic                            pop;
	csvt_pkg::result_t               head;

	assign wr_next = wr_q + 1'b1;
	assign pop     = results.valid && results.ready;
	assign room    = count_q <= (csvt_pkg::FIFO_AW + 1)'(csvt_pkg::FIFO_DEPTH - 2);
	assign head    = mem_q[rd_q];

	// Drive the output channel from the queue head
	assign results.valid         = count_q != '0;
	assign results.out_byte      = head.out_byte;
	assign results.kind          = head.kind;
	assign results.error_code    = head.error_code;
	assign results.column_number = head.column_number;
	assign results.last_of_item  = head.last_of_item;

	// Store incoming results
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push.count[csvt_pkg::FIFO_AW-1:0];
			rd_q    <= rd_q + {{(csvt_pkg::FIFO_AW-1){1'b0}}, pop};
			count_q <= count_q + {{(csvt_pkg::FIFO_AW-1){1'b0}}, push.count}
				- {{csvt_pkg::FIFO_AW{1'b0}}, pop};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> count_q <= (csvt_pkg::FIFO_AW + 1)'(csvt_pkg::FIFO_DEPTH - 2))
		else $error("result queue written without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (csvt_pkg::FIFO_AW + 1)'(csvt_pkg::FIFO_DEPTH))
		else $error("result queue count beyond depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two results for one byte");
`endif

endmodule

>>> rtl/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: line mode register, parser core and result queue.
`timescale 1ns / 1ps

// Takes one CSV byte per transfer on bytes and gives unescaped content bytes, field ends,
// row ends and error marks on results, one result per transfer. A byte is accepted every
// cycle while the four-entry result queue has room for two results; a result reaches
// results after its byte has passed the input register and then the queue. Most bytes
// give zero or one result; a lone CR in CR LF mode comes out together with the byte
// after it, so such a byte can give two results, which leave one at a time through the
// single read port of the result queue. The user must write the line mode through cfg
// only while no byte is in flight; the block itself does not enforce this. cfg is
// always ready. There is no clearing pass after reset.
module csv_field_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	csvt_in_if.sink     bytes,
	csvt_out_if.source  results,
	csvt_cfg_if.sink    cfg
);

	logic [1:0]       line_mode_q;
	logic             room;
	csvt_pkg::push_t  push;

	// Hold the line mode register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q <= csvt_pkg::LINE_CRLF;
		end else if (cfg.valid && cfg.ready) begin
			line_mode_q <= cfg.line_mode;
		end
	end

	csvt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.line_mode (line_mode_q),
		.room      (room),
		.push      (push)
	);

	csvt_result_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.results (results)
	);

endmodule

>>> verif/csvt_token_checker.sv
// Result checker for the CSV field tokenizer: predicts results from accepted bytes and compares.
`timescale 1ns / 1ps

module csvt_token_checker
	import csvt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic              byte_ready,
	input  logic [BYTE_W-1:0] byte_data,
	input  logic              byte_last,
	input  logic              result_valid,
	input  logic              result_ready,
	input  result_t           result_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_mode,
	output int                mismatches,
	output int                pending,
	output int                checked
);

	typedef enum logic [1:0] {
		Q_OUTSIDE,
		Q_INSIDE,
		Q_AFTER
	} quote_state_e;

	// Predicted tokenizer state
	logic [1:0]       line_mode;
	quote_state_e     qstate;
	logic             cr_wait;
	logic             row_fresh;
	logic             learning;
	logic [COL_W-1:0] col_total;
	logic [COL_W-1:0] col_idx;

	// Results of the byte being predicted, then the ones still owed by the block
	result_t staged[2];
	int      staged_n;
	result_t expected_tokens[$];

	int fail_n    = 0;
	int checked_n = 0;

	function automatic void restart_text();
		qstate    = Q_OUTSIDE;
		cr_wait   = 1'b0;
		row_fresh = 1'b1;
		learning  = 1'b1;
		col_total = '0;
		col_idx   = '0;
	endfunction

	function automatic void stage(input logic [BYTE_W-1:0] b, input logic [1:0] k,
		input logic [1:0] e, input logic [COL_W-1:0] col);
		if (staged_n < 2) begin
			staged[staged_n] = '{out_byte: b, kind: k, error_code: e,
				column_number: col, last_of_item: 1'b0};
			staged_n++;
		end
	endfunction

	function automatic void take_content(input logic [BYTE_W-1:0] b);
		stage(b, KIND_CONTENT, ERR_NONE, col_idx);
		row_fresh = 1'b0;
	endfunction

	// Close the row and compare its width with the one learned from the first row
	function automatic void close_row();
		logic [COL_W:0] count;
		logic [1:0]     err;
		count = {1'b0, col_idx} + 1'b1;
		err   = ERR_NONE;
		if (row_fresh)
			return;
		if (learning) begin
			if (count > MAX_COLUMNS) begin
				err       = ERR_TOO_MANY;
				col_total = COL_W'(MAX_COLUMNS);
			end else begin
				col_total = count[COL_W-1:0];
			end
			learning = 1'b0;
		end else if (count < col_total) begin
			err = ERR_SHORT;
		end else if (count > col_total) begin
			err = ERR_TOO_MANY;
		end
		stage('0, (err != ERR_NONE) ? KIND_ERROR : KIND_ROW_END, err, col_idx);
		col_idx   = '0;
		row_fresh = 1'b1;
	endfunction

	function automatic void parse_byte(input logic [BYTE_W-1:0] b);
		// Quoted text: a quote either doubles or closes
		if (qstate == Q_AFTER) begin
			if (b == CH_QUOTE) begin
				take_content(CH_QUOTE);
				qstate = Q_INSIDE;
				return;
			end
			qstate = Q_OUTSIDE;
		end else if (qstate == Q_INSIDE) begin
			if (b == CH_QUOTE)
				qstate = Q_AFTER;
			else
				take_content(b);
			return;
		end

		// A held CR either pairs with LF or turns into content
		if (cr_wait) begin
			cr_wait = 1'b0;
			if (b == CH_LF) begin
				close_row();
				return;
			end
			take_content(CH_CR);
		end

		if (b == CH_QUOTE) begin
			qstate    = Q_INSIDE;
			row_fresh = 1'b0;
		end else if (b == CH_COMMA) begin
			stage('0, KIND_FIELD_END, ERR_NONE, col_idx);
			if (col_idx < MAX_COLUMNS)
				col_idx++;
			row_fresh = 1'b0;
		end else if (b == CH_CR && line_mode == LINE_CRLF) begin
			cr_wait = 1'b1;
		end else if ((b == CH_CR && line_mode >= LINE_ANY) || b == CH_LF) begin
			close_row();
		end else begin
			take_content(b);
		end
	endfunction

	function automatic void tokenize_byte(input logic [BYTE_W-1:0] b, input logic eod);
		staged_n = 0;
		parse_byte(b);
		if (eod) begin
			if (!(row_fresh && qstate == Q_OUTSIDE && !cr_wait)) begin
				staged_n = 0;
				stage('0, KIND_ERROR, ERR_MID_ROW, col_idx);
			end
			restart_text();
		end
		for (int k = 0; k < staged_n; k++) begin
			if (k == staged_n - 1)
				staged[k].last_of_item = 1'b1;
			expected_tokens.push_back(staged[k]);
		end
	endfunction

	function automatic void report_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		fail_n++;
	endfunction

	function automatic void check_result(input result_t got);
		result_t want;
		if (expected_tokens.size() == 0) begin
			$display("%0t: result with nothing expected, expected none, actual %h",
				$time, got);
			fail_n++;
			return;
		end
		want = expected_tokens.pop_front();
		checked_n++;
		if (got.out_byte !== want.out_byte)
			report_field("out_byte", want.out_byte, got.out_byte);
		if (got.kind !== want.kind)
			report_field("kind", 8'(want.kind), 8'(got.kind));
		if (got.error_code !== want.error_code)
			report_field("error_code", 8'(want.error_code), 8'(got.error_code));
		if (got.column_number !== want.column_number)
			report_field("column_number", 8'(want.column_number), 8'(got.column_number));
		if (got.last_of_item !== want.last_of_item)
			report_field("last_of_item", 8'(want.last_of_item), 8'(got.last_of_item));
	endfunction

	// Compare outgoing transfers, track the register, predict incoming bytes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode = LINE_CRLF;
			restart_text();
			expected_tokens.delete();
			pending <= 0;
		end else begin
			if (result_valid && result_ready)
				check_result(result_data);
			if (cfg_valid && cfg_ready)
				line_mode = cfg_mode;
			if (byte_valid && byte_ready)
				tokenize_byte(byte_data, byte_last);
			pending    <= expected_tokens.size();
			mismatches <= fail_n;
			checked    <= checked_n;
		end
	end

endmodule

>>> verif/csv_field_tokenizer_tb.sv
// Top of the CSV field tokenizer testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module csv_field_tokenizer_tb;
	import csvt_pkg::*;

	localparam logic [1:0] LINE_RESERVED = 2'd3;
	localparam int         FLUSH_CYCLES  = 8;
	localparam int         HOLD_CYCLES   = 200;
	localparam int         PHASE_BYTES   = 180;

	logic clk;
	logic arst_n;

	csvt_in_if  byte_ch();
	csvt_out_if result_ch();
	csvt_cfg_if cfg_ch();

	int  mismatches;
	int  pending;
	int  checked;
	int  bytes_sent   = 0;
	bit  tx_idle      = 1'b1;
	bit  rx_idle      = 1'b1;
	bit  hold_request = 1'b0;

	logic [BYTE_W-1:0] text_q[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	csv_field_tokenizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.results(result_ch),
		.cfg    (cfg_ch)
	);

	csvt_token_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_ch.valid),
		.byte_ready  (byte_ch.ready),
		.byte_data   (byte_ch.in_byte),
		.byte_last   (byte_ch.end_of_data),
		.result_valid(result_ch.valid),
		.result_ready(result_ch.ready),
		.result_data ({result_ch.out_byte, result_ch.kind, result_ch.error_code,
			result_ch.column_number, result_ch.last_of_item}),
		.cfg_valid   (cfg_ch.valid),
		.cfg_ready   (cfg_ch.ready),
		.cfg_mode    (cfg_ch.line_mode),
		.mismatches  (mismatches),
		.pending     (pending),
		.checked     (checked)
	);

	// Drain results with random stalls, or one long hold when asked
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				stall        = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 7) : 0;
			end
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eod);
		int gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.in_byte     <= b;
		byte_ch.end_of_data <= eod;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	// Stop offering bytes and wait until the block has nothing left in flight
	task automatic settle();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] mode);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.line_mode <= mode;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(0, 255));
		if (b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF)
			b ^= 8'h40;
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] noise_byte();
		case ($urandom_range(0, 4))
			0:       return CH_QUOTE;
			1:       return CH_COMMA;
			2:       return CH_CR;
			3:       return CH_LF;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic put_terminator(input logic [1:0] mode);
		case (mode)
			LINE_CRLF: begin
				// mostly CR LF, sometimes a bare LF
				if ($urandom_range(0, 3) != 0)
					text_q.push_back(CH_CR);
				text_q.push_back(CH_LF);
			end
			LINE_LF: text_q.push_back(CH_LF);
			default: begin
				case ($urandom_range(0, 2))
					0:       text_q.push_back(CH_CR);
					1:       text_q.push_back(CH_LF);
					default: begin
						text_q.push_back(CH_CR);
						text_q.push_back(CH_LF);
					end
				endcase
			end
		endcase
	endtask

	task automatic put_field();
		int n;
		case ($urandom_range(0, 3))
			0: ;
			1, 2: begin
				// plain field, now and then with a stray CR inside
				n = $urandom_range(1, 3);
				for (int k = 0; k < n; k++) begin
					if ($urandom_range(0, 9) == 0)
						text_q.push_back(CH_CR);
					text_q.push_back(plain_byte());
				end
			end
			default: begin
				// quoted field carrying doubled quotes, commas and line breaks
				text_q.push_back(CH_QUOTE);
				n = $urandom_range(0, 4);
				for (int k = 0; k < n; k++) begin
					case ($urandom_range(0, 4))
						0: begin
							text_q.push_back(CH_QUOTE);
							text_q.push_back(CH_QUOTE);
						end
						1:       text_q.push_back(CH_COMMA);
						2:       text_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
						default: text_q.push_back(plain_byte());
					endcase
				end
				text_q.push_back(CH_QUOTE);
				if ($urandom_range(0, 5) == 0)
					text_q.push_back(plain_byte());
			end
		endcase
	endtask

	// One text: mostly well-formed rows, some ragged, wide or cut short, some pure noise
	task automatic build_text(input logic [1:0] mode);
		int cols;
		int rows;
		int nf;
		int cut;
		int n;
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) text_q.push_back(noise_byte());
			return;
		end
		cols = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 5);
		rows = $urandom_range(1, 5);
		for (int r = 0; r < rows; r++) begin
			nf = cols;
			case ($urandom_range(0, 9))
				0:       nf = (cols > 1) ? cols - 1 : 1;
				1:       nf = cols + 1;
				2:       nf = cols + $urandom_range(2, 6);
				default: ;
			endcase
			if ($urandom_range(0, 7) == 0)
				put_terminator(mode);
			for (int f = 0; f < nf; f++) begin
				if (f != 0)
					text_q.push_back(CH_COMMA);
				if (cols <= 8 || $urandom_range(0, 7) == 0)
					put_field();
			end
			put_terminator(mode);
		end
		if ($urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, text_q.size());
			while (text_q.size() > cut)
				void'(text_q.pop_back());
		end
	endtask

	initial begin
		logic [1:0] phase_mode;
		int         phase_start;
		arst_n              <= 1'b0;
		byte_ch.valid       <= 1'b0;
		byte_ch.in_byte     <= '0;
		byte_ch.end_of_data <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.line_mode    <= LINE_CRLF;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes, quoting, CR handling, row width checks, end of text
		send_byte(8'h00, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte("x", 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte("a", 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte("b", 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte("z", 1'b1);
		send_byte(CH_QUOTE, 1'b1);
		send_byte(CH_CR, 1'b1);
		send_byte(CH_LF, 1'b1);
		settle();

		// Random texts over every line mode, with idle patterns that vary between phases
		for (int p = 0; p < 5; p++) begin
			case (p)
				0:       phase_mode = LINE_LF;
				1:       phase_mode = LINE_ANY;
				2:       phase_mode = LINE_RESERVED;
				3:       phase_mode = LINE_CRLF;
				default: phase_mode = LINE_ANY;
			endcase
			tx_idle = (p != 1 && p != 4);
			rx_idle = (p != 2 && p != 4);
			write_mode(phase_mode);

			if (p == 0) begin
				// hold the output while bytes keep coming so the queue fills up
				hold_request = 1'b1;
				tx_idle      = 1'b0;
				for (int k = 0; k < 30; k++)
					send_byte(plain_byte(), 1'b0);
				send_byte(CH_LF, 1'b1);
				settle();
				tx_idle = 1'b1;
			end

			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				build_text(phase_mode);
				if (text_q.size() == 0)
					text_q.push_back(CH_LF);
				send_text();
			end
			settle();
		end

		$display("Run covered %0d bytes over all four line modes; %0d results compared.",
			bytes_sent, checked);
		$display("Included quoting, lone CR, ragged and wide rows, cut texts, output hold.");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout: stimulus or results stalled");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
